// File: src/llwa_pkg.sv
// llwa_pkg: widths, constants and register codes of the leg load weight allocator
// no dependencies
package llwa_pkg;

  localparam int LEGS    = 4;
  localparam int SCORE_W = 16;
  localparam int GAIN_W  = 16;
  localparam int THR_W   = 15;
  localparam int PROD_W  = SCORE_W + GAIN_W + 1;
  localparam int SUP_W   = 33;
  localparam int SUM_W   = SUP_W + $clog2(LEGS);
  localparam int Q_W     = 16;
  localparam int FRAC_W  = 15;
  localparam int ONE_Q15 = 32768;
  localparam logic [Q_W-1:0] EVEN_SHARE = Q_W'(ONE_Q15 / LEGS);

  typedef logic signed [SCORE_W-1:0] score_t;
  typedef logic [GAIN_W-1:0]         gain_t;
  typedef logic [THR_W-1:0]          thr_t;
  typedef logic [SUP_W-1:0]          sup_t;
  typedef logic [SUM_W-1:0]          sum_t;
  typedef logic [Q_W-1:0]            share_t;

  typedef enum logic [2:0] {
    CFG_CONTACT_GAIN = 3'd0,
    CFG_HEIGHT_GAIN  = 3'd1,
    CFG_TORQUE_GAIN  = 3'd2,
    CFG_MIN_CONTACT  = 3'd3,
    CFG_MIN_SUPPORT  = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    gain_t contact_gain;
    gain_t height_gain;
    gain_t torque_gain;
    thr_t  min_contact;
    thr_t  min_support;
  } cfg_t;

endpackage

// File: src/llwa_lane.sv
// llwa_lane: support of one leg, products then thresholded sum, two stages
// depends on llwa_pkg
module llwa_lane (
  input  logic             clk,
  input  logic             en,
  input  llwa_pkg::cfg_t   cfg,
  input  llwa_pkg::score_t contact,
  input  llwa_pkg::score_t height,
  input  llwa_pkg::score_t torque,
  output llwa_pkg::sup_t   support
);

  localparam int PW = llwa_pkg::PROD_W;

  logic signed [PW-1:0] prod_c_r, prod_h_r, prod_t_r;
  logic                 pass_r;
  llwa_pkg::sup_t       sup_r;
  logic signed [PW+1:0] s;
  logic signed [PW+1:0] floor_q;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_c_r <= contact * $signed({1'b0, cfg.contact_gain});
      prod_h_r <= height  * $signed({1'b0, cfg.height_gain});
      prod_t_r <= torque  * $signed({1'b0, cfg.torque_gain});
      pass_r   <= contact >= $signed({2'b00, cfg.min_contact});
    end
  end

  always_comb begin
    s = (PW+2)'(prod_c_r) + (PW+2)'(prod_h_r) + (PW+2)'(prod_t_r);
    floor_q = $signed((PW+2)'({cfg.min_support, {llwa_pkg::FRAC_W{1'b0}}}));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sup_r <= (pass_r && s >= floor_q) ? s[llwa_pkg::SUP_W-1:0] : '0;
    end
  end

  assign support = sup_r;

endmodule

// File: src/llwa_div.sv
// llwa_div: pipelined restoring divider, one quotient bit per stage
// depends on llwa_pkg
module llwa_div (
  input  logic             clk,
  input  logic             en,
  input  llwa_pkg::sup_t   num,
  input  llwa_pkg::sum_t   den,
  output llwa_pkg::share_t quo
);

  localparam int QW = llwa_pkg::Q_W;
  localparam int RW = llwa_pkg::SUM_W + 1;

  logic [RW-1:0]             rem_r [QW];
  llwa_pkg::sum_t            den_r [QW];
  logic [QW-1:0]             quo_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [RW-1:0]  t;
    llwa_pkg::sum_t d;
    logic [QW-1:0]  qp;
    logic           ge;
    if (k == 0) begin : g_first
      assign t  = RW'(num);
      assign d  = den;
      assign qp = '0;
    end else begin : g_next
      assign t  = {rem_r[k-1][RW-2:0], 1'b0};
      assign d  = den_r[k-1];
      assign qp = quo_r[k-1];
    end
    assign ge = t >= RW'(d);
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? t - RW'(d) : t;
        den_r[k] <= d;
        quo_r[k] <= {qp[QW-2:0], ge};
      end
    end
  end

  assign quo = quo_r[QW-1];

endmodule

// File: src/leg_load_weight_allocator_unit.sv
// leg_load_weight_allocator_unit: top level, lanes, support sum and share dividers
// depends on llwa_pkg, llwa_lane, llwa_div
// Takes one beat per clock when the output is drained; a beat's result passes
// through 20 register stages (2 lane stages for products and thresholds, 1 for the
// support sum, 16 for the per-leg restoring divider at one quotient bit per stage,
// 1 output register). The whole pipeline stalls only while a result waits on
// out_ready. Registers are written through the cfg port, which is always ready.
module leg_load_weight_allocator_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  llwa_pkg::score_t      in_contact_a,
  input  llwa_pkg::score_t      in_height_a,
  input  llwa_pkg::score_t      in_torque_a,
  input  llwa_pkg::score_t      in_contact_b,
  input  llwa_pkg::score_t      in_height_b,
  input  llwa_pkg::score_t      in_torque_b,
  input  llwa_pkg::score_t      in_contact_c,
  input  llwa_pkg::score_t      in_height_c,
  input  llwa_pkg::score_t      in_torque_c,
  input  llwa_pkg::score_t      in_contact_d,
  input  llwa_pkg::score_t      in_height_d,
  input  llwa_pkg::score_t      in_torque_d,
  output logic                  out_valid,
  input  logic                  out_ready,
  output llwa_pkg::share_t      out_share_a,
  output llwa_pkg::share_t      out_share_b,
  output llwa_pkg::share_t      out_share_c,
  output llwa_pkg::share_t      out_share_d,
  output logic                  out_even_split,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [2:0]            cfg_index,
  input  logic [15:0]           cfg_data
);

  localparam int L     = llwa_pkg::LEGS;
  localparam int DIV_D = llwa_pkg::Q_W;
  localparam int PRE_D = 3;

  llwa_pkg::cfg_t   cfg_r;
  logic             en;
  llwa_pkg::score_t con [L];
  llwa_pkg::score_t hgt [L];
  llwa_pkg::score_t trq [L];
  llwa_pkg::sup_t   sup [L];
  llwa_pkg::sup_t   sup_r [L];
  llwa_pkg::sum_t   sum_nxt;
  llwa_pkg::sum_t   sum_r;
  llwa_pkg::share_t quo [L];
  logic [PRE_D-1:0] pre_vld_r;
  logic [DIV_D-1:0] div_vld_r;
  logic [DIV_D-1:0] div_even_r;
  logic             out_valid_r;
  logic             even_r;
  llwa_pkg::share_t share_r [L];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.contact_gain <= 16'd16384;
      cfg_r.height_gain  <= 16'd11469;
      cfg_r.torque_gain  <= 16'd4915;
      cfg_r.min_contact  <= 15'd819;
      cfg_r.min_support  <= 15'd205;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        llwa_pkg::CFG_CONTACT_GAIN: cfg_r.contact_gain <= cfg_data;
        llwa_pkg::CFG_HEIGHT_GAIN:  cfg_r.height_gain  <= cfg_data;
        llwa_pkg::CFG_TORQUE_GAIN:  cfg_r.torque_gain  <= cfg_data;
        llwa_pkg::CFG_MIN_CONTACT:  cfg_r.min_contact  <= cfg_data[14:0];
        llwa_pkg::CFG_MIN_SUPPORT:  cfg_r.min_support  <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  assign con[0] = in_contact_a; assign hgt[0] = in_height_a; assign trq[0] = in_torque_a;
  assign con[1] = in_contact_b; assign hgt[1] = in_height_b; assign trq[1] = in_torque_b;
  assign con[2] = in_contact_c; assign hgt[2] = in_height_c; assign trq[2] = in_torque_c;
  assign con[3] = in_contact_d; assign hgt[3] = in_height_d; assign trq[3] = in_torque_d;

  for (genvar i = 0; i < L; i++) begin : g_lane
    llwa_lane u_lane (
      .clk     (clk),
      .en      (en),
      .cfg     (cfg_r),
      .contact (con[i]),
      .height  (hgt[i]),
      .torque  (trq[i]),
      .support (sup[i])
    );
    llwa_div u_div (
      .clk (clk),
      .en  (en),
      .num (sup_r[i]),
      .den (sum_r),
      .quo (quo[i])
    );
  end

  // merge: sum of kept supports
  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < L; i++) begin
      sum_nxt = sum_nxt + llwa_pkg::SUM_W'(sup[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r <= sum_nxt;
      for (int i = 0; i < L; i++) sup_r[i] <= sup[i];
      div_even_r <= {div_even_r[DIV_D-2:0], sum_r == '0};
      even_r <= div_even_r[DIV_D-1];
      for (int i = 0; i < L; i++) begin
        share_r[i] <= div_even_r[DIV_D-1] ? llwa_pkg::EVEN_SHARE : quo[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_vld_r   <= '0;
      div_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      pre_vld_r   <= {pre_vld_r[PRE_D-2:0], in_valid};
      div_vld_r   <= {div_vld_r[DIV_D-2:0], pre_vld_r[PRE_D-1]};
      out_valid_r <= div_vld_r[DIV_D-1];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_even_split = even_r;
  assign out_share_a    = share_r[0];
  assign out_share_b    = share_r[1];
  assign out_share_c    = share_r[2];
  assign out_share_d    = share_r[3];

`ifndef SYNTH
  a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow output stall");

  a_even_shares: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_even_split |->
      out_share_a == llwa_pkg::EVEN_SHARE && out_share_d == llwa_pkg::EVEN_SHARE)
    else $error("even split without even shares");

  a_share_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_even_split |->
      (18'(out_share_a) + 18'(out_share_b) + 18'(out_share_c) + 18'(out_share_d))
        <= 18'(llwa_pkg::ONE_Q15))
    else $error("shares exceed one");
`endif

endmodule
